[src/cie_pkg.sv]
// shared types and constants for the cbor item encoder
`default_nettype none
package cie_pkg;

    // request codes
    localparam logic [3:0] OP_UINT    = 4'd0;
    localparam logic [3:0] OP_INT     = 4'd1;
    localparam logic [3:0] OP_BYTES   = 4'd2;
    localparam logic [3:0] OP_TEXT    = 4'd3;
    localparam logic [3:0] OP_ARRAY   = 4'd4;
    localparam logic [3:0] OP_MAP     = 4'd5;
    localparam logic [3:0] OP_BOOL    = 4'd6;
    localparam logic [3:0] OP_NULL    = 4'd7;
    localparam logic [3:0] OP_FLOAT   = 4'd8;
    localparam logic [3:0] OP_PAYLOAD = 4'd9;

    // major types
    localparam logic [2:0] MAJOR_UINT = 3'd0;
    localparam logic [2:0] MAJOR_NINT = 3'd1;

    // fixed simple-value bytes
    localparam logic [7:0] SIMPLE_FALSE = 8'hf4;
    localparam logic [7:0] SIMPLE_TRUE  = 8'hf5;
    localparam logic [7:0] SIMPLE_NULL  = 8'hf6;
    localparam logic [7:0] FLOAT32_LEAD = 8'hfa;

    // additional info codes
    localparam logic [4:0] AI_ONE   = 5'd24;
    localparam logic [4:0] AI_TWO   = 5'd25;
    localparam logic [4:0] AI_FOUR  = 5'd26;
    localparam logic [4:0] AI_EIGHT = 5'd27;

    // one formatted item: lead byte, argument bytes aligned to the top, byte count
    typedef struct packed {
        logic        emit;
        logic [7:0]  lead;
        logic [63:0] data;
        logic [3:0]  count;
    } head_t;

endpackage
`default_nettype wire

[src/cie_head.sv]
// formats one request into lead byte, aligned argument and byte count
`default_nettype none
module cie_head (
    input  wire logic [3:0]  op,
    input  wire logic [63:0] value,
    output cie_pkg::head_t   head
);
    import cie_pkg::*;

    logic [2:0]  major;
    logic [63:0] arg;
    logic        is_head;
    logic [4:0]  ai;
    logic [63:0] arg_aligned;
    logic [3:0]  arg_bytes;

    // major type and argument for the integer and head requests
    always_comb begin
        is_head = 1'b1;
        major   = op[2:0];
        arg     = value;
        case (op)
            OP_UINT: begin
                major = MAJOR_UINT;
            end
            OP_INT: begin
                if (value[63]) begin
                    major = MAJOR_NINT;
                    arg   = ~value;
                end else begin
                    major = MAJOR_UINT;
                end
            end
            OP_BYTES, OP_TEXT, OP_ARRAY, OP_MAP: begin
                major = op[2:0];
            end
            default: begin
                is_head = 1'b0;
            end
        endcase
    end

    // shortest argument form
    always_comb begin
        if (arg[63:5] == 59'd0 && arg[4:3] != 2'b11) begin
            ai          = arg[4:0];
            arg_bytes   = 4'd0;
            arg_aligned = 64'd0;
        end else if (arg[63:8] == 56'd0) begin
            ai          = AI_ONE;
            arg_bytes   = 4'd1;
            arg_aligned = {arg[7:0], 56'd0};
        end else if (arg[63:16] == 48'd0) begin
            ai          = AI_TWO;
            arg_bytes   = 4'd2;
            arg_aligned = {arg[15:0], 48'd0};
        end else if (arg[63:32] == 32'd0) begin
            ai          = AI_FOUR;
            arg_bytes   = 4'd4;
            arg_aligned = {arg[31:0], 32'd0};
        end else begin
            ai          = AI_EIGHT;
            arg_bytes   = 4'd8;
            arg_aligned = arg;
        end
    end

    // final selection per request
    always_comb begin
        head.emit  = 1'b1;
        head.lead  = {major, ai};
        head.data  = arg_aligned;
        head.count = arg_bytes + 4'd1;
        if (!is_head) begin
            head.data  = 64'd0;
            head.count = 4'd1;
            case (op)
                OP_BOOL: begin
                    head.lead = value[0] ? SIMPLE_TRUE : SIMPLE_FALSE;
                end
                OP_NULL: begin
                    head.lead = SIMPLE_NULL;
                end
                OP_FLOAT: begin
                    head.lead  = FLOAT32_LEAD;
                    head.data  = {value[31:0], 32'd0};
                    head.count = 4'd5;
                end
                OP_PAYLOAD: begin
                    head.lead = value[7:0];
                end
                default: begin
                    head.emit = 1'b0;
                    head.lead = 8'd0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[src/cie_serializer.sv]
// byte shift register that sends one formatted item a byte per cycle while the receiver is ready
`default_nettype none
module cie_serializer (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load,
    input  wire cie_pkg::head_t load_head,
    output logic                free,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [7:0]          m_byte_out,
    output logic                m_last
);
    import cie_pkg::*;

    logic [71:0] shift_reg, shift_next;
    logic [3:0]  remain_reg, remain_next;
    logic        take;

    assign m_valid    = (remain_reg != 4'd0);
    assign m_byte_out = shift_reg[71:64];
    assign m_last     = (remain_reg == 4'd1);
    assign take       = m_valid && m_ready;
    // free when empty or the final byte leaves this cycle
    assign free       = !m_valid || (take && m_last);

    // load a new item or shift out the byte just taken
    always_comb begin
        shift_next  = shift_reg;
        remain_next = remain_reg;
        if (load) begin
            shift_next  = {load_head.lead, load_head.data};
            remain_next = load_head.count;
        end else if (take) begin
            shift_next  = {shift_reg[63:0], 8'd0};
            remain_next = remain_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        if (!aresetn) begin
            remain_reg <= 4'd0;
        end else begin
            remain_reg <= remain_next;
        end
    end

endmodule
`default_nettype wire

[src/cbor_item_encoder_unit.sv]
// top level of the cbor item encoder
//
// Encodes one request per input item into CBOR bytes, one byte per result
// item, with m_last set on the final byte of each request.
// Input channel: s_valid/s_ready with s_op and s_value. Result channel:
// m_valid/m_ready with m_byte_out and m_last.
// The first byte of a request passes the input register, then the byte
// shift register, before it is offered on the result channel.
// Each request has 1 to 9 bytes; the byte shift register sends one byte
// per cycle while the receiver is ready and reloads in the cycle its
// final byte is taken, so consecutive requests leave no gap.
// Requests with an unused op code produce no bytes.
// Reset (aresetn low, synchronous) empties the input register and the
// byte shift register; nothing else is kept.
// When the receiver stalls, the current byte holds; the next request
// waits in the input register and s_ready drops until it can move on.
`default_nettype none
module cbor_item_encoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [3:0]  s_op,
    input  wire logic [63:0] s_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_byte_out,
    output logic             m_last
);
    import cie_pkg::*;

    logic        hold_valid_reg, hold_valid_next;
    logic [3:0]  hold_op_reg;
    logic [63:0] hold_value_reg;
    head_t       head;
    logic        ser_free;
    logic        consume;
    logic        accept;

    // format the held request
    cie_head u_head (
        .op    (hold_op_reg),
        .value (hold_value_reg),
        .head  (head)
    );

    // held item moves on when it has no bytes or the shift register is free
    assign consume = hold_valid_reg && (!head.emit || ser_free);
    assign s_ready = !hold_valid_reg || consume;
    assign accept  = s_valid && s_ready;

    cie_serializer u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (consume && head.emit),
        .load_head  (head),
        .free       (ser_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_byte_out (m_byte_out),
        .m_last     (m_last)
    );

    // input register
    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (accept) begin
            hold_valid_next = 1'b1;
        end else if (consume) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_op_reg    <= s_op;
            hold_value_reg <= s_value;
        end
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

endmodule
`default_nettype wire
